// ----- design/coalescing_command_queue_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef COALESCING_COMMAND_QUEUE_UNIT_MACROS_SVH
`define COALESCING_COMMAND_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define CCQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ccq_pkg.sv -----
package ccq_pkg;

    typedef enum logic [2:0] {
        OP_STAGE = 3'd0,
        OP_PUSH  = 3'd1,
        OP_READ  = 3'd2,
        OP_PULL  = 3'd3,
        OP_PEEK  = 3'd4,
        OP_CLEAR = 3'd5
    } t_opcode;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_EXEC   = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic decode;
        logic exec;
        logic clr_step;
        logic out_valid;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_clear;
        logic clear_done;
    } t_ctrl_sts;

endpackage

// ----- design/coalescing_command_queue_unit.sv -----
// Coalescing command queue: a FIFO of commands, each a 32-bit id with a payload
// held in a slot of the payload memory.
// Slave stream carries one command item per handshake: tuser is the opcode
// (stage word, push, read head word, pull, peek, clear), tdata the operands.
// Master stream returns exactly one result item per command: tuser is the
// status, tdata holds head id, head length and the read payload word.
// An item is taken in the idle state, decoded (id match against all queued
// entries, payload memory read or write issued), then executed, and then
// shown on the master side. Clear adds a sweep in which the slots of the
// queued entries go back to the free pool one per cycle.
// Items are handled one at a time: no new item is taken until the result of
// the last one has been taken, as decode, execute and result hand-off run
// as one sequence with a single shared execute step.
// The slave side is not ready while a result waits; a master stall holds the
// result and the whole block.
// Reset (synchronous, active low) empties the queue and restores the free pool
// at once; payload memory contents and entry fields are not cleared.
module coalescing_command_queue_unit #(
    parameter int QUEUE_DEPTH       = 8,
    parameter int MAX_PAYLOAD_BYTES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // command_id[31:0], payload_length[47:32], coalesce[48],
    // payload_word[112:49], word_position[119:113]
    input  logic [119:0] i_s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // head_id[31:0], head_length[42:32], read_word[106:43], zero pad above
    output logic [111:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]   o_m_axis_tuser
);
    localparam int SLOT_WORDS = (MAX_PAYLOAD_BYTES + 7) / 8;
    localparam int RAM_DEPTH  = (QUEUE_DEPTH + 1) * SLOT_WORDS;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    ccq_pkg::t_ctrl_cmd cmd;
    ccq_pkg::t_ctrl_sts sts;

    logic              ram_wr_en, ram_rd_en;
    logic [RAM_AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [63:0]       ram_wr_data, ram_rd_data;

    // sequence decode, execute, clear sweep and result hand-off
    ccq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // queue bookkeeping, id match and result formation
    ccq_datapath #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .RAM_AW            (RAM_AW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_data     (i_s_axis_tdata),
        .i_in_user     (i_s_axis_tuser),
        .o_out_data    (o_m_axis_tdata),
        .o_out_user    (o_m_axis_tuser),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    // payload slots: staging slot plus one per queue entry
    ccq_ram #(
        .WIDTH (64),
        .DEPTH (RAM_DEPTH)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_s_axis_tready = cmd.in_ready;
    assign o_m_axis_tvalid = cmd.out_valid;
endmodule

// ----- design/ccq_ram.sv -----
module ccq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1152
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- design/ccq_ctrl.sv -----
module ccq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  ccq_pkg::t_ctrl_sts i_sts,
    output ccq_pkg::t_ctrl_cmd o_cmd
);
    ccq_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ccq_pkg::S_IDLE:   if (i_in_valid) n_state = ccq_pkg::S_DECODE;
            ccq_pkg::S_DECODE: n_state = ccq_pkg::S_EXEC;
            ccq_pkg::S_EXEC:   n_state = i_sts.is_clear ? ccq_pkg::S_CLEAR : ccq_pkg::S_OUT;
            ccq_pkg::S_CLEAR:  if (i_sts.clear_done) n_state = ccq_pkg::S_OUT;
            ccq_pkg::S_OUT:    if (i_out_ready) n_state = ccq_pkg::S_IDLE;
            default:           n_state = ccq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.in_ready  = (r_state == ccq_pkg::S_IDLE);
        o_cmd.capture   = (r_state == ccq_pkg::S_IDLE) && i_in_valid;
        o_cmd.decode    = (r_state == ccq_pkg::S_DECODE);
        o_cmd.exec      = (r_state == ccq_pkg::S_EXEC);
        o_cmd.clr_step  = (r_state == ccq_pkg::S_CLEAR);
        o_cmd.out_valid = (r_state == ccq_pkg::S_OUT);
    end
endmodule

// ----- design/ccq_datapath.sv -----
module ccq_datapath #(
    parameter int QUEUE_DEPTH       = 8,
    parameter int MAX_PAYLOAD_BYTES = 1024,
    parameter int RAM_AW            = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ccq_pkg::t_ctrl_cmd                i_cmd,
    output ccq_pkg::t_ctrl_sts                o_sts,
    input  logic [ccq_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [2:0]                        i_in_user,
    output logic [ccq_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic [1:0]                        o_out_user,
    output logic                              o_ram_wr_en,
    output logic [RAM_AW-1:0]                 o_ram_wr_addr,
    output logic [63:0]                       o_ram_wr_data,
    output logic                              o_ram_rd_en,
    output logic [RAM_AW-1:0]                 o_ram_rd_addr,
    input  logic [63:0]                       i_ram_rd_data
);
    localparam int SLOT_WORDS = (MAX_PAYLOAD_BYTES + 7) / 8;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(MAX_PAYLOAD_BYTES + 1);

    // captured item
    ccq_pkg::t_opcode r_op;
    logic [31:0] r_id;
    logic [15:0] r_len;
    logic        r_coal;
    logic [63:0] r_word;
    logic [6:0]  r_pos;

    // queue state
    logic [31:0]   r_ids   [QUEUE_DEPTH];
    logic [LW-1:0] r_lens  [QUEUE_DEPTH];
    logic [CW-1:0] r_slots [QUEUE_DEPTH];
    logic [CW-1:0] r_free  [QUEUE_DEPTH + 1];
    logic [CW-1:0] r_stage;
    logic [QW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_hit;
    logic [QW-1:0] r_hit_idx;

    // result
    logic [1:0]  r_status;
    logic [31:0] r_hid;
    logic [10:0] r_hlen;
    logic [63:0] r_rword;

    logic          n_hit;
    logic [QW-1:0] n_hit_idx;
    logic [1:0]    n_status;
    logic [31:0]   n_hid;
    logic [10:0]   n_hlen;
    logic [63:0]   n_rword;
    logic          do_coal, do_append, do_pull;
    logic          pos_ok;
    logic [QW-1:0] tail_idx, head_next;
    logic [CW-1:0] fidx;
    logic [15:0]   p8, hl16, remain;
    logic [63:0]   byte_mask;

    function automatic logic [QW-1:0] wrap_idx(input logic [QW:0] s);
        logic [QW:0] t;
        t = (s >= (QW+1)'(QUEUE_DEPTH)) ? s - (QW+1)'(QUEUE_DEPTH) : s;
        return t[QW-1:0];
    endfunction

    assign pos_ok    = (32'(r_pos) < SLOT_WORDS);
    assign tail_idx  = wrap_idx({1'b0, r_head} + (QW+1)'(r_count));
    assign head_next = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign fidx      = CW'(QUEUE_DEPTH) - r_count;
    assign p8        = 16'({r_pos, 3'b000});
    assign hl16      = 16'(r_lens[r_head]);
    assign remain    = hl16 - p8;
    assign byte_mask = (remain < 16'd8) ? (64'd1 << {remain[2:0], 3'b000}) - 64'd1 : '1;

    // first queued entry with a matching id, searched from the head
    always_comb begin
        logic [QW-1:0] h;
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            h = wrap_idx({1'b0, r_head} + (QW+1)'(i));
            if (!n_hit && (CW'(i) < r_count) && (r_ids[h] == r_id)) begin
                n_hit     = 1'b1;
                n_hit_idx = h;
            end
        end
    end

    always_comb begin
        n_status  = ccq_pkg::ST_OK;
        n_hid     = '0;
        n_hlen    = '0;
        n_rword   = '0;
        do_coal   = 1'b0;
        do_append = 1'b0;
        do_pull   = 1'b0;
        case (r_op)
            ccq_pkg::OP_PUSH: begin
                if (r_len > 16'(MAX_PAYLOAD_BYTES)) begin
                    n_status = ccq_pkg::ST_TOO_LONG;
                end else if (r_coal && r_hit) begin
                    do_coal = 1'b1;
                end else if (r_count >= CW'(QUEUE_DEPTH)) begin
                    n_status = ccq_pkg::ST_FULL;
                end else begin
                    do_append = 1'b1;
                end
            end
            ccq_pkg::OP_READ: begin
                if (r_count == '0) begin
                    n_status = ccq_pkg::ST_EMPTY;
                end else if (pos_ok && (p8 < hl16)) begin
                    n_rword = i_ram_rd_data & byte_mask;
                end
            end
            ccq_pkg::OP_PULL, ccq_pkg::OP_PEEK: begin
                if (r_count == '0) begin
                    n_status = ccq_pkg::ST_EMPTY;
                end else begin
                    n_hid   = r_ids[r_head];
                    n_hlen  = 11'(r_lens[r_head]);
                    do_pull = (r_op == ccq_pkg::OP_PULL);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QUEUE_DEPTH; i++) begin
                r_free[i] <= CW'(i);
            end
            r_stage <= CW'(QUEUE_DEPTH);
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (do_coal) begin
                r_stage <= r_slots[r_hit_idx];
            end else if (do_append) begin
                r_stage <= r_free[fidx - 1'b1];
                r_count <= r_count + 1'b1;
            end else if (do_pull) begin
                r_free[fidx] <= r_slots[r_head];
                r_count      <= r_count - 1'b1;
                r_head       <= head_next;
            end
        end else if (i_cmd.clr_step && (r_count != '0)) begin
            r_free[fidx] <= r_slots[r_head];
            r_count      <= r_count - 1'b1;
            r_head       <= head_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= ccq_pkg::t_opcode'(i_in_user);
            r_id   <= i_in_data[31:0];
            r_len  <= i_in_data[47:32];
            r_coal <= i_in_data[48];
            r_word <= i_in_data[112:49];
            r_pos  <= i_in_data[119:113];
        end
        if (i_cmd.decode) begin
            r_hit     <= n_hit;
            r_hit_idx <= n_hit_idx;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_hid    <= n_hid;
            r_hlen   <= n_hlen;
            r_rword  <= n_rword;
            if (do_coal) begin
                r_slots[r_hit_idx] <= r_stage;
                r_lens[r_hit_idx]  <= LW'(r_len);
            end else if (do_append) begin
                r_ids[tail_idx]   <= r_id;
                r_lens[tail_idx]  <= LW'(r_len);
                r_slots[tail_idx] <= r_stage;
            end
        end
    end

    assign o_ram_wr_en   = i_cmd.decode && (r_op == ccq_pkg::OP_STAGE) && pos_ok;
    assign o_ram_wr_addr = RAM_AW'(r_stage) * RAM_AW'(SLOT_WORDS) + RAM_AW'(r_pos);
    assign o_ram_wr_data = r_word;
    assign o_ram_rd_en   = i_cmd.decode;
    assign o_ram_rd_addr = RAM_AW'(r_slots[r_head]) * RAM_AW'(SLOT_WORDS) + RAM_AW'(r_pos);

    assign o_sts.is_clear   = (r_op == ccq_pkg::OP_CLEAR);
    assign o_sts.clear_done = (r_count == '0);

    assign o_out_data = {5'd0, r_rword, r_hlen, r_hid};
    assign o_out_user = r_status;
endmodule

// ----- design/ccq_checker.sv -----
`include "coalescing_command_queue_unit_macros.svh"

module ccq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [111:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser
);
    `CCQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")
    `CCQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready && !o_m_axis_tvalid, "second item taken while busy")
    `CCQ_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready, "ready while a result waits")
    `CCQ_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready, "not idle after reset")
endmodule

bind coalescing_command_queue_unit ccq_checker u_ccq_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    localparam int DEPTH      = 8;
    localparam int MAX_BYTES  = 1024;
    localparam int SLOT_WORDS = MAX_BYTES / 8;
    localparam int SLOTS      = DEPTH + 1;
    localparam int CYCLE_CAP  = 400000;
    localparam int RANDOM_ITEMS = 700;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] cmd_id;
        logic [15:0] length;
        logic        coalesce;
        logic [63:0] word;
        logic [6:0]  pos;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] head_id;
        logic [10:0] head_len;
        logic [63:0] read_word;
    } t_res;

    // Queue model plus the list of results still owed by the block.
    class queue_scoreboard;
        logic [31:0] ids [DEPTH];
        int unsigned lens [DEPTH];
        int unsigned slots [DEPTH];
        logic [63:0] store [SLOTS][SLOT_WORDS];
        bit          written [SLOTS][SLOT_WORDS];
        int unsigned free_pool [SLOTS];
        int unsigned staging;
        int unsigned head;
        int unsigned count;
        t_res        owed [$];
        int          errors;
        int          accepted;
        int          checked;
        int          status_seen [4];
        int          coalesced;

        function new();
            for (int i = 0; i < SLOTS; i++) free_pool[i] = i;
            for (int s = 0; s < SLOTS; s++)
                for (int w = 0; w < SLOT_WORDS; w++) begin
                    store[s][w] = '0;
                    written[s][w] = 0;
                end
            staging = DEPTH;
            head = 0;
            count = 0;
            errors = 0;
            accepted = 0;
            checked = 0;
            coalesced = 0;
            for (int i = 0; i < 4; i++) status_seen[i] = 0;
        endfunction

        function int unsigned slot_at(int unsigned offset);
            return (head + offset) % DEPTH;
        endfunction

        // Return the head slot to the free stack and advance the head.
        function void pop_head();
            free_pool[DEPTH - count] = slots[slot_at(0)];
            count--;
            head = slot_at(1);
        endfunction

        function void note(t_cmd c);
            t_res r;
            int unsigned h;
            int unsigned s;
            int unsigned remain;
            bit hit;
            r = '0;
            hit = 0;
            accepted++;
            case (c.opcode)
                ccq_pkg::OP_STAGE: begin
                    store[staging][c.pos] = c.word;
                    written[staging][c.pos] = 1;
                end
                ccq_pkg::OP_PUSH: begin
                    if (c.length > MAX_BYTES) begin
                        r.status = ccq_pkg::ST_TOO_LONG;
                    end else begin
                        if (c.coalesce) begin
                            for (int i = 0; i < count; i++) begin
                                h = slot_at(i);
                                if (!hit && ids[h] == c.cmd_id) begin
                                    hit = 1;
                                    s = slots[h];
                                    slots[h] = staging;
                                    staging = s;
                                    lens[h] = c.length;
                                    coalesced++;
                                end
                            end
                        end
                        if (!hit) begin
                            if (count >= DEPTH) begin
                                r.status = ccq_pkg::ST_FULL;
                            end else begin
                                h = slot_at(count);
                                ids[h] = c.cmd_id;
                                lens[h] = c.length;
                                slots[h] = staging;
                                staging = free_pool[DEPTH - count - 1];
                                count++;
                            end
                        end
                    end
                end
                ccq_pkg::OP_READ: begin
                    if (count == 0) begin
                        r.status = ccq_pkg::ST_EMPTY;
                    end else begin
                        h = slot_at(0);
                        if (c.pos * 8 < lens[h]) begin
                            remain = lens[h] - c.pos * 8;
                            r.read_word = store[slots[h]][c.pos];
                            if (remain < 8)
                                r.read_word &= (64'd1 << (remain * 8)) - 64'd1;
                        end
                    end
                end
                ccq_pkg::OP_PULL, ccq_pkg::OP_PEEK: begin
                    if (count == 0) begin
                        r.status = ccq_pkg::ST_EMPTY;
                    end else begin
                        h = slot_at(0);
                        r.head_id = ids[h];
                        r.head_len = lens[h];
                        if (c.opcode == ccq_pkg::OP_PULL) pop_head();
                    end
                end
                ccq_pkg::OP_CLEAR: begin
                    while (count > 0) pop_head();
                end
                default: ;
            endcase
            status_seen[r.status]++;
            owed.push_back(r);
        endfunction

        function void check(t_res got);
            t_res want;
            if (owed.size() == 0) begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.head_id !== want.head_id) begin
                $error("head_id: expected %h, got %h", want.head_id, got.head_id);
                errors++;
            end
            if (got.head_len !== want.head_len) begin
                $error("head_length: expected %0d, got %0d", want.head_len, got.head_len);
                errors++;
            end
            if (got.read_word !== want.read_word) begin
                $error("read_word: expected %h, got %h", want.read_word, got.read_word);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [119:0] i_s_axis_tdata;
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [111:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    queue_scoreboard book;
    int  cycles;
    bit  long_hold_done;

    coalescing_command_queue_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check every result item taken on the master side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            book.check({o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[42:32],
                        o_m_axis_tdata[106:43]});
    end

    // Receiver: random stalls per result, plus one long hold-off mid-run so the
    // block holds its result and stops taking commands.
    initial begin
        int gap;
        i_m_axis_tready = 0;
        long_hold_done = 0;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (!long_hold_done && book.accepted >= 300) begin
                long_hold_done = 1;
                gap = 300;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_m_axis_tready = 0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Offer one command; hold it until the block takes it, then predict.
    task automatic send_cmd(t_cmd c, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tuser = c.opcode;
        i_s_axis_tdata = {c.pos, c.word, c.coalesce, c.length, c.cmd_id};
        i_s_axis_tvalid = 1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        book.note(c);
    endtask

    // Hold the sender until every owed result has come back.
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 0;
        while (book.owed.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_cmd make_cmd(logic [2:0] op, logic [31:0] id, int unsigned len,
                                      bit co, logic [63:0] w, int unsigned p);
        t_cmd c;
        c.opcode = op;
        c.cmd_id = id;
        c.length = len;
        c.coalesce = co;
        c.word = w;
        c.pos = p;
        return c;
    endfunction

    // Never read a head word that was not staged since reset: move the index
    // to a staged word or past the length, or fall back to a peek.
    function automatic t_cmd make_read_safe(t_cmd c);
        int unsigned s;
        int unsigned len;
        if (c.opcode != ccq_pkg::OP_READ || book.count == 0) return c;
        s = book.slots[book.slot_at(0)];
        len = book.lens[book.slot_at(0)];
        if (c.pos * 8 >= len || book.written[s][c.pos]) return c;
        for (int w = 0; w * 8 < len; w++)
            if (book.written[s][w]) begin
                c.pos = w;
                return c;
            end
        if (len <= MAX_BYTES - 8) c.pos = (len + 7) / 8;
        else c.opcode = ccq_pkg::OP_PEEK;
        return c;
    endfunction

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int unsigned roll;
        c.cmd_id = pick_id();
        c.coalesce = $urandom_range(0, 1);
        c.word = {$urandom(), $urandom()};
        roll = $urandom_range(0, 9);
        c.length = (roll == 0) ? $urandom_range(1025, 65535) :
                   (roll < 4)  ? $urandom_range(0, 40) : $urandom_range(0, MAX_BYTES);
        c.pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
        roll = $urandom_range(0, 99);
        if (roll < 35)      c.opcode = ccq_pkg::OP_STAGE;
        else if (roll < 60) c.opcode = ccq_pkg::OP_PUSH;
        else if (roll < 75) c.opcode = ccq_pkg::OP_READ;
        else if (roll < 87) c.opcode = ccq_pkg::OP_PULL;
        else if (roll < 94) c.opcode = ccq_pkg::OP_PEEK;
        else if (roll < 97) c.opcode = ccq_pkg::OP_CLEAR;
        else                c.opcode = roll[0] ? OP_SPARE_A : OP_SPARE_B;
        return make_read_safe(c);
    endfunction

    initial begin
        book = new();
        cycles = 0;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = ccq_pkg::OP_STAGE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: empty-queue answers, length limits, partial words,
        // coalescing hits, full queue, spare opcodes, clear.
        send_cmd(make_cmd(ccq_pkg::OP_PEEK, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PULL, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_READ, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_STAGE, 0, 0, 0, '1, 127), 0);
        send_cmd(make_cmd(ccq_pkg::OP_STAGE, 0, 0, 0, 64'h0123_4567_89AB_CDEF, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_STAGE, 0, 0, 0, 64'hFEDC_BA98_7654_3210, 1), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PUSH, 32'h7FFF_FFFF, 1025, 1, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PUSH, 32'h7FFF_FFFF, 65535, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PUSH, 32'h8000_0000, 13, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_READ, 0, 0, 0, 0, 1), 0);
        send_cmd(make_cmd(ccq_pkg::OP_READ, 0, 0, 0, 0, 2), 0);
        send_cmd(make_cmd(ccq_pkg::OP_STAGE, 0, 0, 0, 64'hA5A5_5A5A_F0F0_0F0F, 127), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PUSH, 32'h8000_0000, MAX_BYTES, 1, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_READ, 0, 0, 0, 0, 127), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PUSH, 32'h8000_0000, 0, 0, 0, 0), 0);
        for (int i = 0; i < DEPTH; i++)
            send_cmd(make_cmd(ccq_pkg::OP_PUSH, i, i, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PUSH, 32'h0000_0003, 5, 1, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PEEK, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(OP_SPARE_A, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(OP_SPARE_B, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_PULL, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(ccq_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0);
        drain();

        // Random: bursts without gaps alternate with gapped stretches.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 450) drain();
            send_cmd(random_cmd(), (n / 40) % 3 == 1);
        end
        drain();
        repeat (30) @(posedge i_clk);

        $display("Covered %0d commands, %0d results checked, %0d coalesced pushes.",
                 book.accepted, book.checked, book.coalesced);
        $display("Status counts: ok %0d, empty %0d, too long %0d, full %0d.",
                 book.status_seen[ccq_pkg::ST_OK], book.status_seen[ccq_pkg::ST_EMPTY],
                 book.status_seen[ccq_pkg::ST_TOO_LONG],
                 book.status_seen[ccq_pkg::ST_FULL]);
        if (book.errors == 0 && book.owed.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
